[hw/rtl/mta_pkg.sv]
// Shared constants, types and arithmetic helpers for the mesh tangent accumulator.
`default_nettype none
package mta_pkg;

    localparam int IDX_W        = 10;
    localparam int VERTEX_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int FRAC_BITS    = 16;
    localparam int SUM_W        = 48;
    localparam int DIV_W        = 64 + FRAC_BITS;
    localparam int QUO_W        = SUM_W + 1;
    localparam int OUT_FRAC     = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int CNT_W        = ADDR_W;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_TRI  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Multiplier operand selects. Triangle products use the codes below MS_SQ0.
    localparam logic [3:0] MS_DET0 = 4'd0;
    localparam logic [3:0] MS_DET1 = 4'd1;
    localparam logic [3:0] MS_NX0  = 4'd2;
    localparam logic [3:0] MS_NX1  = 4'd3;
    localparam logic [3:0] MS_NY0  = 4'd4;
    localparam logic [3:0] MS_NY1  = 4'd5;
    localparam logic [3:0] MS_NZ0  = 4'd6;
    localparam logic [3:0] MS_NZ1  = 4'd7;
    localparam logic [3:0] MS_SQ0  = 4'd8;
    localparam logic [3:0] MS_SQ1  = 4'd9;
    localparam logic [3:0] MS_SQ2  = 4'd10;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } t_vtx;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_sum;

    typedef struct packed {
        logic              cap_req;
        logic              vload;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
        logic              vrd_en;
        logic [1:0]        vrd_sel;
        logic              vcap_en;
        logic [1:0]        vcap_sel;
        logic              delta_en;
        logic              mul_en;
        logic [3:0]        mul_sel;
        logic              acc_en;
        logic [3:0]        acc_sel;
        logic              div_load;
        logic              div_mode;
        logic              div_step;
        logic              tsat_en;
        logic              srd_en;
        logic              swr_en;
        logic [1:0]        corner;
        logic              mag_en;
        logic              norm_step;
        logic              sq_load;
        logic              sq_step;
        logic              out_load;
        logic              out_degen;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       a_ok;
        logic       abc_ok;
        logic       det_zero;
        logic       sum_zero;
        logic       norm_done;
    } t_stat;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < VERTEX_DEPTH;
    endfunction

    function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return d[31:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add48(input logic signed [SUM_W-1:0] a,
                                                          input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [SUM_W-1:0] mag48(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    // Quotient magnitude to signed 48-bit tangent component, clamped.
    function automatic logic signed [SUM_W-1:0] tan_comp(input logic [QUO_W-1:0] q,
                                                         input logic ovf,
                                                         input logic neg);
        logic big;
        big = ovf | q[QUO_W-1] | q[SUM_W-1];
        if (neg) begin
            return big ? SUM_MIN : SUM_W'(-q[SUM_W-1:0]);
        end
        return big ? SUM_MAX : q[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/mta_div.sv]
// Restoring divider lane, one quotient bit per step, with a sticky quotient overflow flag.
`default_nettype none
module mta_div import mta_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_load,
    input  wire logic             i_step,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [63:0]      i_divisor,
    output logic      [QUO_W-1:0] o_quot,
    output logic                  o_ovf
);

    logic [63:0]      r_rem;
    logic [DIV_W-1:0] r_dvd;
    logic [QUO_W-1:0] r_quo;
    logic             r_ovf;
    logic [64:0]      trial;
    logic [64:0]      diff;
    logic             fits;

    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign fits  = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (i_step) begin
            r_rem <= fits ? diff[63:0] : trial[63:0];
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            // A bit shifted out of the top means the quotient has overflowed for good.
            r_ovf <= r_ovf | r_quo[QUO_W-1];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_quot = r_quo;
    assign o_ovf  = r_ovf;

endmodule
`default_nettype wire

[hw/rtl/mta_dp.sv]
// Datapath: vertex and sum memories, multiplier, divider lanes, square root, output register.
`default_nettype none
module mta_dp import mta_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_st,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [IDX_W-1:0]   i_vertex_a,
    input  wire logic [IDX_W-1:0]   i_vertex_b,
    input  wire logic [IDX_W-1:0]   i_vertex_c,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_tex_u,
    input  wire logic signed [31:0] i_tex_v,
    output logic signed [31:0]      o_tangent_x,
    output logic signed [31:0]      o_tangent_y,
    output logic signed [31:0]      o_tangent_z,
    output logic                    o_degenerate
);

    logic [1:0]         r_req;
    logic [IDX_W-1:0]   r_ia, r_ib, r_ic;
    t_vtx               r_ld;

    t_vtx               r_vmem [VERTEX_DEPTH];
    t_vtx               r_vrd;
    t_vtx               r_c0, r_c1, r_c2;
    t_sum               r_smem [VERTEX_DEPTH];
    t_sum               r_srd;

    logic signed [31:0] r_d1 [3];
    logic signed [31:0] r_d2 [3];
    logic signed [31:0] r_du1, r_dv1, r_du2, r_dv2;

    logic signed [63:0] r_prod;
    logic signed [63:0] r_det;
    logic signed [63:0] r_num [3];
    logic [63:0]        r_sq;

    logic               r_neg [3];
    t_sum               r_t;
    logic [SUM_W-1:0]   r_m [3];

    logic [63:0]        r_sx, r_res, r_bit;

    logic signed [31:0] r_ox, r_oy, r_oz;
    logic               r_odg;

    logic [IDX_W-1:0]   corner_idx;
    logic [ADDR_W-1:0]  s_waddr;
    logic               s_we;
    t_sum               s_wdata;
    logic signed [31:0] op_a, op_b;
    logic [SUM_W-1:0]   mx01, mx;
    logic [63:0]        sq_try;
    logic [DIV_W-1:0]   dvd [3];
    logic [63:0]        divisor;
    logic [QUO_W-1:0]   quo [3];
    logic               ovf [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_req) begin
            r_req <= i_req_type;
            r_ia  <= i_vertex_a;
            r_ib  <= i_vertex_b;
            r_ic  <= i_vertex_c;
            r_ld  <= '{x: i_pos_x, y: i_pos_y, z: i_pos_z, u: i_tex_u, v: i_tex_v};
        end
    end

    always_comb begin
        unique case (i_cmd.corner | i_cmd.vrd_sel)
            2'd0:    corner_idx = r_ia;
            2'd1:    corner_idx = r_ib;
            2'd2:    corner_idx = r_ic;
            default: corner_idx = r_ia;
        endcase
    end

    // Vertex store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.vload) begin
            r_vmem[r_ia[ADDR_W-1:0]] <= r_ld;
        end
        if (i_cmd.vrd_en) begin
            r_vrd <= r_vmem[corner_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vcap_en) begin
            unique case (i_cmd.vcap_sel)
                2'd0:    r_c0 <= r_vrd;
                2'd1:    r_c1 <= r_vrd;
                default: r_c2 <= r_vrd;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.delta_en) begin
            r_d1[0] <= sat_sub32(r_c1.x, r_c0.x);
            r_d1[1] <= sat_sub32(r_c1.y, r_c0.y);
            r_d1[2] <= sat_sub32(r_c1.z, r_c0.z);
            r_d2[0] <= sat_sub32(r_c2.x, r_c0.x);
            r_d2[1] <= sat_sub32(r_c2.y, r_c0.y);
            r_d2[2] <= sat_sub32(r_c2.z, r_c0.z);
            r_du1   <= sat_sub32(r_c1.u, r_c0.u);
            r_dv1   <= sat_sub32(r_c1.v, r_c0.v);
            r_du2   <= sat_sub32(r_c2.u, r_c0.u);
            r_dv2   <= sat_sub32(r_c2.v, r_c0.v);
        end
    end

    // Shared multiplier with a product register and a lagging accumulate step.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DET0: begin op_a = r_du1;   op_b = r_dv2; end
            MS_DET1: begin op_a = r_dv1;   op_b = r_du2; end
            MS_NX0:  begin op_a = r_d1[0]; op_b = r_dv2; end
            MS_NX1:  begin op_a = r_d2[0]; op_b = r_dv1; end
            MS_NY0:  begin op_a = r_d1[1]; op_b = r_dv2; end
            MS_NY1:  begin op_a = r_d2[1]; op_b = r_dv1; end
            MS_NZ0:  begin op_a = r_d1[2]; op_b = r_dv2; end
            MS_NZ1:  begin op_a = r_d2[2]; op_b = r_dv1; end
            MS_SQ0:  begin op_a = r_m[0][31:0]; op_b = r_m[0][31:0]; end
            MS_SQ1:  begin op_a = r_m[1][31:0]; op_b = r_m[1][31:0]; end
            MS_SQ2:  begin op_a = r_m[2][31:0]; op_b = r_m[2][31:0]; end
            default: begin op_a = '0;      op_b = '0;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.acc_en) begin
            unique case (i_cmd.acc_sel)
                MS_DET0: r_det    <= r_prod;
                MS_DET1: r_det    <= r_det - r_prod;
                MS_NX0:  r_num[0] <= r_prod;
                MS_NX1:  r_num[0] <= r_num[0] - r_prod;
                MS_NY0:  r_num[1] <= r_prod;
                MS_NY1:  r_num[1] <= r_num[1] - r_prod;
                MS_NZ0:  r_num[2] <= r_prod;
                MS_NZ1:  r_num[2] <= r_num[2] - r_prod;
                MS_SQ0:  r_sq     <= 64'(r_prod);
                MS_SQ1:  r_sq     <= r_sq + 64'(r_prod);
                MS_SQ2:  r_sq     <= r_sq + 64'(r_prod);
                default: r_sq     <= r_sq;
            endcase
        end
    end

    // Divider lanes: triangle mode divides the scaled numerators by the determinant,
    // read mode divides the normalized magnitudes by the vector length.
    assign divisor = i_cmd.div_mode ? {32'd0, r_res[31:0]} : mag64(r_det);

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign dvd[g] = i_cmd.div_mode ? (DIV_W'(r_m[g][30:0]) << OUT_FRAC)
                                       : {mag64(r_num[g]), {FRAC_BITS{1'b0}}};
        mta_div u_div (
            .i_clk      (i_clk),
            .i_load     (i_cmd.div_load),
            .i_step     (i_cmd.div_step),
            .i_dividend (dvd[g]),
            .i_divisor  (divisor),
            .o_quot     (quo[g]),
            .o_ovf      (ovf[g])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.div_load && !i_cmd.div_mode) begin
                r_neg[i] <= r_num[i][63] ^ r_det[63];
            end else if (i_cmd.mag_en) begin
                r_neg[i] <= (i == 0) ? r_srd.x[SUM_W-1] :
                            (i == 1) ? r_srd.y[SUM_W-1] : r_srd.z[SUM_W-1];
            end
        end
        if (i_cmd.tsat_en) begin
            r_t.x <= tan_comp(quo[0], ovf[0], r_neg[0]);
            r_t.y <= tan_comp(quo[1], ovf[1], r_neg[1]);
            r_t.z <= tan_comp(quo[2], ovf[2], r_neg[2]);
        end
    end

    // Tangent sum store: cleared by the reset sweep and by vertex loads.
    always_comb begin
        s_we    = 1'b1;
        s_waddr = corner_idx[ADDR_W-1:0];
        s_wdata = '{x: sat_add48(r_srd.x, r_t.x), y: sat_add48(r_srd.y, r_t.y),
                    z: sat_add48(r_srd.z, r_t.z)};
        priority if (i_cmd.clr_we) begin
            s_waddr = i_cmd.clr_addr;
            s_wdata = '0;
        end else if (i_cmd.vload) begin
            s_waddr = r_ia[ADDR_W-1:0];
            s_wdata = '0;
        end else if (!i_cmd.swr_en) begin
            s_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_waddr] <= s_wdata;
        end
        if (i_cmd.srd_en) begin
            r_srd <= r_smem[corner_idx[ADDR_W-1:0]];
        end
    end

    // Magnitudes and block normalization into [2^30, 2^31).
    assign mx01 = (r_m[0] > r_m[1]) ? r_m[0] : r_m[1];
    assign mx   = (mx01 > r_m[2]) ? mx01 : r_m[2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mag_en) begin
            r_m[0] <= mag48(r_srd.x);
            r_m[1] <= mag48(r_srd.y);
            r_m[2] <= mag48(r_srd.z);
        end else if (i_cmd.norm_step) begin
            for (int i = 0; i < 3; i++) begin
                if (|mx[SUM_W-1:31]) begin
                    r_m[i] <= r_m[i] >> 1;
                end else begin
                    r_m[i] <= r_m[i] << 1;
                end
            end
        end
    end

    // Integer square root, two radicand bits per step.
    assign sq_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_sx  <= r_sq;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
        end else if (i_cmd.sq_step) begin
            if (r_sx >= sq_try) begin
                r_sx  <= r_sx - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odg <= i_cmd.out_degen;
            if (i_cmd.out_degen) begin
                r_ox <= '0;
                r_oy <= '0;
                r_oz <= '0;
            end else begin
                r_ox <= r_neg[0] ? -quo[0][31:0] : quo[0][31:0];
                r_oy <= r_neg[1] ? -quo[1][31:0] : quo[1][31:0];
                r_oz <= r_neg[2] ? -quo[2][31:0] : quo[2][31:0];
            end
        end
    end

    assign o_tangent_x  = r_ox;
    assign o_tangent_y  = r_oy;
    assign o_tangent_z  = r_oz;
    assign o_degenerate = r_odg;

    assign o_st.req       = r_req;
    assign o_st.a_ok      = in_range(r_ia);
    assign o_st.abc_ok    = in_range(r_ia) & in_range(r_ib) & in_range(r_ic);
    assign o_st.det_zero  = (r_det == '0);
    assign o_st.sum_zero  = (mx == '0);
    assign o_st.norm_done = ~(|mx[SUM_W-1:31]) & (|mx[SUM_W-1:30]);

endmodule
`default_nettype wire

[hw/rtl/mta_ctrl.sv]
// Controller: sequences the datapath for loads, triangles and reads, and holds the channel flags.
`default_nettype none
module mta_ctrl import mta_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_st,
    output t_cmd       o_cmd
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_TRD   = 5'd3;
    localparam logic [4:0] S_DELTA = 5'd4;
    localparam logic [4:0] S_MUL   = 5'd5;
    localparam logic [4:0] S_DCHK  = 5'd6;
    localparam logic [4:0] S_DIV   = 5'd7;
    localparam logic [4:0] S_TSAT  = 5'd8;
    localparam logic [4:0] S_ACCR  = 5'd9;
    localparam logic [4:0] S_ACCW  = 5'd10;
    localparam logic [4:0] S_RMAG  = 5'd11;
    localparam logic [4:0] S_RZ    = 5'd12;
    localparam logic [4:0] S_NORM  = 5'd13;
    localparam logic [4:0] S_SQ    = 5'd14;
    localparam logic [4:0] S_SQI   = 5'd15;
    localparam logic [4:0] S_SQRT  = 5'd16;
    localparam logic [4:0] S_RDL   = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_degen, n_degen;
    logic             r_rmode, n_rmode;
    logic             r_out_vld, n_out_vld;
    logic             out_free;
    t_cmd             cmd;

    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_degen = r_degen;
        n_rmode = r_rmode;
        cmd     = '0;
        cmd.corner = r_cnt[1:0];
        unique case (r_state)
            S_CLR: begin
                cmd.clr_we   = 1'b1;
                cmd.clr_addr = r_cnt[ADDR_W-1:0];
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VERTEX_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap_req = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                n_cnt   = '0;
                n_state = S_IDLE;
                unique case (i_st.req)
                    REQ_LOAD: cmd.vload = i_st.a_ok;
                    REQ_TRI: begin
                        if (i_st.abc_ok) begin
                            n_state = S_TRD;
                        end
                    end
                    REQ_READ: begin
                        n_rmode = 1'b1;
                        if (i_st.a_ok) begin
                            cmd.srd_en = 1'b1;
                            cmd.corner = 2'd0;
                            n_state    = S_RMAG;
                        end else begin
                            n_degen = 1'b1;
                            n_state = S_OUT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TRD: begin
                // Corner reads overlap with capture of the previous read.
                cmd.corner   = 2'd0;
                cmd.vrd_en   = (r_cnt != CNT_W'(3));
                cmd.vrd_sel  = r_cnt[1:0];
                cmd.vcap_en  = (r_cnt != '0);
                cmd.vcap_sel = 2'(r_cnt - 1'b1);
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(3)) begin
                    n_state = S_DELTA;
                end
            end
            S_DELTA: begin
                cmd.delta_en = 1'b1;
                n_cnt        = '0;
                n_state      = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en  = (r_cnt != CNT_W'(8));
                cmd.mul_sel = 4'(r_cnt);
                cmd.acc_en  = (r_cnt != '0);
                cmd.acc_sel = 4'(r_cnt - 1'b1);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(8)) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                n_rmode = 1'b0;
                n_cnt   = '0;
                if (i_st.det_zero) begin
                    n_state = S_IDLE;
                end else begin
                    cmd.div_load = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_cnt   = '0;
                    n_degen = 1'b0;
                    n_state = r_rmode ? S_OUT : S_TSAT;
                end
            end
            S_TSAT: begin
                cmd.tsat_en = 1'b1;
                n_cnt       = '0;
                n_state     = S_ACCR;
            end
            S_ACCR: begin
                cmd.srd_en = 1'b1;
                n_state    = S_ACCW;
            end
            S_ACCW: begin
                cmd.swr_en = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                n_state    = (r_cnt == CNT_W'(2)) ? S_IDLE : S_ACCR;
            end
            S_RMAG: begin
                cmd.mag_en = 1'b1;
                n_state    = S_RZ;
            end
            S_RZ: begin
                if (i_st.sum_zero) begin
                    n_degen = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_cnt = '0;
                if (i_st.norm_done) begin
                    n_state = S_SQ;
                end else begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_SQ: begin
                cmd.mul_en  = (r_cnt != CNT_W'(3));
                cmd.mul_sel = MS_SQ0 + 4'(r_cnt);
                cmd.acc_en  = (r_cnt != '0);
                cmd.acc_sel = MS_SQ0 + 4'(r_cnt - 1'b1);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(3)) begin
                    n_state = S_SQI;
                end
            end
            S_SQI: begin
                cmd.sq_load = 1'b1;
                n_cnt       = '0;
                n_state     = S_SQRT;
            end
            S_SQRT: begin
                cmd.sq_step = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_RDL;
                end
            end
            S_RDL: begin
                cmd.div_mode = 1'b1;
                cmd.div_load = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_OUT: begin
                cmd.div_mode = 1'b1;
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_degen = r_degen;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // The divider reads its mode every step, so hold it through a read.
        if (r_state == S_DIV) begin
            cmd.div_mode = r_rmode;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_degen   <= 1'b0;
            r_rmode   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_degen   <= n_degen;
            r_rmode   <= n_rmode;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire

[hw/rtl/mesh_tangent_accumulator_top.sv]
// Mesh tangent accumulator: per-vertex tangents built from positions and texture coordinates.
//
// Input channel (i_in_valid / o_in_ready) takes one request per transaction: vertex load,
// triangle accumulate or tangent read. Only a read produces a transaction on the output
// channel (o_out_valid / i_out_ready), carrying a Q2.30 unit tangent and a degenerate flag.
// Requests are processed one at a time by a controller and a shared datapath.
// A triangle runs three corner reads, ten deltas, eight products through one 32x32 multiplier,
// an 80-step restoring division (three lanes in parallel), and three read-modify-writes of the
// tangent sum memory; a zero determinant ends the triangle before the division.
// A read runs the sum read, a loop of up to 30 normalizing shifts, three squares, a 32-step
// square root and the 80-step division. A read of a zero sum skips these steps and returns
// a degenerate result. The result is loaded at the edge that ends the read.
// After reset the block runs a clearing pass over the sum memory and holds o_in_ready low
// until it ends. Vertex positions are not cleared.
// The result sits in an output register; the block keeps accepting new requests while it
// waits, and only a second read stalls at its end until the receiver takes the first.
`default_nettype none
module mesh_tangent_accumulator_top import mta_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [IDX_W-1:0]   i_vertex_a,
    input  wire logic [IDX_W-1:0]   i_vertex_b,
    input  wire logic [IDX_W-1:0]   i_vertex_c,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_tex_u,
    input  wire logic signed [31:0] i_tex_v,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_tangent_x,
    output logic signed [31:0]      o_tangent_y,
    output logic signed [31:0]      o_tangent_z,
    output logic                    o_degenerate
);

    t_cmd  cmd;
    t_stat st;

    mta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    mta_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_req_type   (i_req_type),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .i_vertex_c   (i_vertex_c),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .o_tangent_x  (o_tangent_x),
        .o_tangent_y  (o_tangent_y),
        .o_tangent_z  (o_tangent_z),
        .o_degenerate (o_degenerate)
    );

endmodule
`default_nettype wire

[test/mesh_tangent_accumulator_top_tb.sv]
// Self-checking testbench for the mesh tangent accumulator with a predicting scoreboard.
`timescale 1ns / 1ps

module mesh_tangent_accumulator_top_tb;
    import mta_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int NUM_RANDOM = 1380;
    localparam int HOLD_CYCLES = 900;
    localparam int HOLD_AT_ITEM = 300;

    typedef struct {
        logic [1:0]         req;
        logic [IDX_W-1:0]   a, b, c;
        logic signed [31:0] px, py, pz, u, v;
    } tan_req_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               degen;
    } tan_res_t;

    class tangent_scoreboard;
        logic signed [31:0]      pos_x [VERTEX_DEPTH];
        logic signed [31:0]      pos_y [VERTEX_DEPTH];
        logic signed [31:0]      pos_z [VERTEX_DEPTH];
        logic signed [31:0]      uv_u [VERTEX_DEPTH];
        logic signed [31:0]      uv_v [VERTEX_DEPTH];
        logic signed [SUM_W-1:0] acc_x [VERTEX_DEPTH];
        logic signed [SUM_W-1:0] acc_y [VERTEX_DEPTH];
        logic signed [SUM_W-1:0] acc_z [VERTEX_DEPTH];
        tan_res_t                tangent_q[$];
        int errors, loads, triangles, flat_triangles, reads, degen_reads, saturated;

        function void clear_all();
            for (int i = 0; i < VERTEX_DEPTH; i++) begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0; uv_u[i] = 0; uv_v[i] = 0;
                acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
            end
        endfunction

        function longint clamp_delta(logic signed [31:0] p, logic signed [31:0] q);
            longint d;
            d = longint'(p) - longint'(q);
            if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
            if (d < -64'sh8000_0000) d = -64'sh8000_0000;
            return d;
        endfunction

        // Quotient num * 2^FRAC_BITS / den, toward zero, clamped to 48 bits.
        function logic signed [SUM_W-1:0] frac_quotient(longint num, longint den);
            bit [63:0] n, d, q, r, m;
            bit neg;
            n = (num < 0) ? 64'(-num) : 64'(num);
            d = (den < 0) ? 64'(-den) : 64'(den);
            neg = (num < 0) != (den < 0);
            q = n / d;
            r = n % d;
            if (q > (64'd1 << (47 - FRAC_BITS))) begin
                m = 64'd1 << 47;
            end else begin
                m = q;
                for (int i = 0; i < FRAC_BITS; i++) begin
                    r = r << 1;
                    m = m << 1;
                    if (r >= d) begin
                        r = r - d;
                        m[0] = 1'b1;
                    end
                end
                if (m > (64'd1 << 47)) m = 64'd1 << 47;
            end
            if (neg) return SUM_W'(-m);
            return (m > 64'h7FFF_FFFF_FFFF) ? SUM_MAX : SUM_W'(m);
        endfunction

        function logic signed [SUM_W-1:0] add_clamped(logic signed [SUM_W-1:0] s,
                                                       logic signed [SUM_W-1:0] t);
            longint w;
            w = longint'(s) + longint'(t);
            if (w > longint'(SUM_MAX)) begin
                saturated++;
                return SUM_MAX;
            end
            if (w < longint'(SUM_MIN)) begin
                saturated++;
                return SUM_MIN;
            end
            return SUM_W'(w);
        endfunction

        function bit [63:0] root_floor(bit [63:0] x);
            bit [63:0] res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt = bt >> 2;
            while (bt != 0) begin
                if (x >= res + bt) begin
                    x = x - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            return res;
        endfunction

        function void add_triangle(int a, int b, int c);
            longint dx1, dy1, dz1, dx2, dy2, dz2, du1, dv1, du2, dv2, det;
            logic signed [SUM_W-1:0] tx, ty, tz;
            int corner [3];
            dx1 = clamp_delta(pos_x[b], pos_x[a]);
            dy1 = clamp_delta(pos_y[b], pos_y[a]);
            dz1 = clamp_delta(pos_z[b], pos_z[a]);
            dx2 = clamp_delta(pos_x[c], pos_x[a]);
            dy2 = clamp_delta(pos_y[c], pos_y[a]);
            dz2 = clamp_delta(pos_z[c], pos_z[a]);
            du1 = clamp_delta(uv_u[b], uv_u[a]);
            dv1 = clamp_delta(uv_v[b], uv_v[a]);
            du2 = clamp_delta(uv_u[c], uv_u[a]);
            dv2 = clamp_delta(uv_v[c], uv_v[a]);
            det = du1 * dv2 - dv1 * du2;
            if (det == 0) begin
                flat_triangles++;
                return;
            end
            tx = frac_quotient(dx1 * dv2 - dx2 * dv1, det);
            ty = frac_quotient(dy1 * dv2 - dy2 * dv1, det);
            tz = frac_quotient(dz1 * dv2 - dz2 * dv1, det);
            corner = '{a, b, c};
            foreach (corner[k]) begin
                acc_x[corner[k]] = add_clamped(acc_x[corner[k]], tx);
                acc_y[corner[k]] = add_clamped(acc_y[corner[k]], ty);
                acc_z[corner[k]] = add_clamped(acc_z[corner[k]], tz);
            end
        endfunction

        function tan_res_t unit_tangent(int a);
            tan_res_t res;
            logic signed [SUM_W-1:0] s [3];
            bit [63:0] m [3];
            bit [63:0] mx, n, q;
            res = '{x: 0, y: 0, z: 0, degen: 1'b1};
            s = '{acc_x[a], acc_y[a], acc_z[a]};
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = s[i][SUM_W-1] ? 64'(-longint'(s[i])) : 64'(longint'(s[i]));
                if (m[i] > mx) mx = m[i];
            end
            if (mx == 0) return res;
            while (mx >= (64'd1 << 31)) begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < (64'd1 << 30)) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            n = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int i = 0; i < 3; i++) begin
                q = (m[i] << 30) / n;
                if (s[i] < 0) q = -q;
                if (i == 0) res.x = q[31:0];
                if (i == 1) res.y = q[31:0];
                if (i == 2) res.z = q[31:0];
            end
            res.degen = 1'b0;
            return res;
        endfunction

        function void note_request(tan_req_t r);
            case (r.req)
                REQ_LOAD: begin
                    loads++;
                    pos_x[r.a] = r.px; pos_y[r.a] = r.py; pos_z[r.a] = r.pz;
                    uv_u[r.a] = r.u; uv_v[r.a] = r.v;
                    acc_x[r.a] = 0; acc_y[r.a] = 0; acc_z[r.a] = 0;
                end
                REQ_TRI: begin
                    triangles++;
                    add_triangle(r.a, r.b, r.c);
                end
                REQ_READ: begin
                    reads++;
                    tangent_q.push_back(unit_tangent(r.a));
                end
                default: ;
            endcase
        endfunction

        function void check_result(tan_res_t got);
            tan_res_t exp_r;
            if (tangent_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected tangent transaction x=%h y=%h z=%h degen=%b",
                         $time, got.x, got.y, got.z, got.degen);
                return;
            end
            exp_r = tangent_q.pop_front();
            if (exp_r.degen) degen_reads++;
            if (got.x !== exp_r.x) begin
                errors++;
                $display("%0t: tangent_x expected %h actual %h", $time, exp_r.x, got.x);
            end
            if (got.y !== exp_r.y) begin
                errors++;
                $display("%0t: tangent_y expected %h actual %h", $time, exp_r.y, got.y);
            end
            if (got.z !== exp_r.z) begin
                errors++;
                $display("%0t: tangent_z expected %h actual %h", $time, exp_r.z, got.z);
            end
            if (got.degen !== exp_r.degen) begin
                errors++;
                $display("%0t: degenerate expected %b actual %b", $time, exp_r.degen,
                         got.degen);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_req_type;
    logic [IDX_W-1:0]        i_vertex_a, i_vertex_b, i_vertex_c;
    logic signed [31:0]      i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [31:0]      o_tangent_x, o_tangent_y, o_tangent_z;
    logic                    o_degenerate;

    tangent_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;
    int  accepted;
    bit  loaded [VERTEX_DEPTH];
    int  loaded_list[$];

    mesh_tangent_accumulator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b),
        .i_vertex_c(i_vertex_c), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_tex_u(i_tex_u), .i_tex_v(i_tex_v),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_tangent_x(o_tangent_x), .o_tangent_y(o_tangent_y), .o_tangent_z(o_tangent_z),
        .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off that backs up the block.
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && accepted >= HOLD_AT_ITEM) begin
                held = 1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result('{x: o_tangent_x, y: o_tangent_y, z: o_tangent_z,
                              degen: o_degenerate});
        end
    end

    task automatic issue(tan_req_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_req_type = r.req;
        i_vertex_a = r.a; i_vertex_b = r.b; i_vertex_c = r.c;
        i_pos_x = r.px; i_pos_y = r.py; i_pos_z = r.pz;
        i_tex_u = r.u; i_tex_v = r.v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(r);
        accepted++;
        if (r.req == REQ_LOAD && !loaded[r.a]) begin
            loaded[r.a] = 1;
            loaded_list.push_back(r.a);
        end
    endtask

    task automatic load_vertex(int idx, int x, int y, int z, int u, int v);
        issue('{req: REQ_LOAD, a: IDX_W'(idx), b: IDX_W'($urandom), c: IDX_W'($urandom),
                px: x, py: y, pz: z, u: u, v: v});
    endtask

    task automatic simple_req(logic [1:0] kind, int a, int b, int c);
        issue('{req: kind, a: IDX_W'(a), b: IDX_W'(b), c: IDX_W'(c),
                px: $urandom, py: $urandom, pz: $urandom,
                u: $urandom, v: $urandom});
    endtask

    function automatic int rand_coord();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return $signed($urandom_range(65535)) - 32768;
            default: return ($signed($urandom_range(16 << 16)) - (8 << 16));
        endcase
    endfunction

    task automatic random_item();
        int k, a, b, c;
        k = $urandom_range(99);
        if (k < 30 || loaded_list.size() < 3) begin
            a = ($urandom_range(9) < 7) ? $urandom_range(31) : $urandom_range(1023);
            if ($urandom_range(19) == 0 && loaded_list.size() > 0) begin
                // Reuse a loaded UV so some triangles come out flat.
                b = loaded_list[$urandom_range(loaded_list.size() - 1)];
                load_vertex(a, rand_coord(), rand_coord(), rand_coord(), sb.uv_u[b],
                            sb.uv_v[b]);
            end else begin
                load_vertex(a, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord());
            end
        end else if (k < 72) begin
            a = loaded_list[$urandom_range(loaded_list.size() - 1)];
            b = loaded_list[$urandom_range(loaded_list.size() - 1)];
            c = loaded_list[$urandom_range(loaded_list.size() - 1)];
            simple_req(REQ_TRI, a, b, c);
        end else if (k < 96) begin
            a = ($urandom_range(3) != 0)
                ? loaded_list[$urandom_range(loaded_list.size() - 1)] : $urandom_range(1023);
            simple_req(REQ_READ, a, $urandom, $urandom);
        end else begin
            simple_req(REQ_NONE, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int waited;
        sb = new();
        sb.clear_all();
        accepted = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_LOAD;
        i_vertex_a = '0; i_vertex_b = '0; i_vertex_c = '0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0; i_tex_u = '0; i_tex_v = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty sums, clamped quotients, sum saturation, flat UV,
        // repeated corners, extreme indices and an unknown request.
        simple_req(REQ_READ, 5, 0, 0);
        load_vertex(0, 0, 0, 0, 0, 0);
        load_vertex(1, 32'h7FFF_FFFF, 32'h8000_0000, 1 << 16, 1, 0);
        load_vertex(2, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1);
        simple_req(REQ_TRI, 0, 1, 2);
        simple_req(REQ_TRI, 0, 1, 2);
        simple_req(REQ_READ, 0, 0, 0);
        simple_req(REQ_READ, 1, 0, 0);
        load_vertex(3, 5 << 16, 1 << 16, 7, 0, 0);
        simple_req(REQ_TRI, 0, 3, 1);
        simple_req(REQ_TRI, 0, 0, 1);
        simple_req(REQ_READ, 3, 0, 0);
        load_vertex(5, 1 << 16, 0, 0, 1 << 16, 0);
        load_vertex(6, 0, 1 << 16, 0, 0, 1 << 16);
        simple_req(REQ_TRI, 0, 5, 6);
        simple_req(REQ_READ, 5, 0, 0);
        load_vertex(1023, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000);
        simple_req(REQ_TRI, 1023, 5, 6);
        simple_req(REQ_READ, 1023, 0, 0);
        simple_req(REQ_NONE, 10'h3FF, 10'h3FF, 10'h3FF);
        simple_req(REQ_READ, 6, 0, 0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n < NUM_RANDOM / 3) begin
                send_idle_pct = 16; recv_idle_pct = 46;
            end else if (n < 2 * NUM_RANDOM / 3) begin
                send_idle_pct = 46; recv_idle_pct = 16;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            random_item();
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        waited = 0;
        while (sb.tangent_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);

        $display("Covered %0d loads, %0d triangles (%0d with zero determinant), %0d reads",
                 sb.loads, sb.triangles, sb.flat_triangles, sb.reads);
        $display("Degenerate reads %0d, saturated sum updates %0d, mismatches %0d",
                 sb.degen_reads, sb.saturated, sb.errors);
        if (sb.errors == 0 && sb.tangent_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
